/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hw/rtl/sip_pkg.sv */
`default_nettype none
package sip_pkg;
  localparam int OUT_BITS = 24;
  localparam int QDEPTH = 8;
  localparam int FRONT_LAT = 5;
  localparam int DIV_LAT = OUT_BITS + 3;

  typedef struct packed {
    logic empty;
    logic full;
  } sip_qstat_t;
endpackage
`default_nettype wire

/* hw/rtl/sip_front.sv */
`default_nettype none
module sip_front #(
  parameter int CB = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   vld_in,
  input  wire logic signed [CB-1:0]   asx,
  input  wire logic signed [CB-1:0]   asy,
  input  wire logic signed [CB-1:0]   aex,
  input  wire logic signed [CB-1:0]   aey,
  input  wire logic signed [CB-1:0]   bsx,
  input  wire logic signed [CB-1:0]   bsy,
  input  wire logic signed [CB-1:0]   bex,
  input  wire logic signed [CB-1:0]   bey,
  output logic                        vld_out,
  output logic                        hit_out,
  output logic signed [3*CB+4:0]      numx_out,
  output logic signed [3*CB+4:0]      numy_out,
  output logic signed [2*CB+2:0]      det_out
);
  import sip_pkg::*;

  localparam int DW = CB + 1;
  localparam int PW = 2 * CB + 2;
  localparam int KW = 2 * CB + 3;
  localparam int MW = 3 * CB + 4;
  localparam int NW = 3 * CB + 5;

  logic [FRONT_LAT-1:0] vld_r;

  logic signed [DW-1:0] dax1_r, day1_r, dbx1_r, dby1_r;
  logic signed [CB-1:0] asx_r, asy_r, aex_r, aey_r, bsx_r, bsy_r, bex_r, bey_r;

  logic signed [PW-1:0] p_r [14];
  logic signed [DW-1:0] dax2_r, day2_r, dbx2_r, dby2_r;

  logic signed [KW-1:0] ca_r, cb_r, det3_r;
  logic signed [DW-1:0] dax3_r, day3_r, dbx3_r, dby3_r;
  logic                 hit3_r;

  logic signed [KW-1:0] ca_nxt, cb_nxt, tas_nxt, tae_nxt, tbs_nxt, tbe_nxt, det_nxt;
  logic                 hit_nxt;

  logic signed [MW-1:0] m1_r, m2_r, m3_r, m4_r;
  logic signed [KW-1:0] det4_r;
  logic                 hit4_r;

  logic signed [NW-1:0] numx_r, numy_r;
  logic signed [KW-1:0] det5_r;
  logic                 hit5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FRONT_LAT-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    dax1_r <= DW'(aex) - DW'(asx);
    day1_r <= DW'(aey) - DW'(asy);
    dbx1_r <= DW'(bex) - DW'(bsx);
    dby1_r <= DW'(bey) - DW'(bsy);
    asx_r  <= asx;
    asy_r  <= asy;
    aex_r  <= aex;
    aey_r  <= aey;
    bsx_r  <= bsx;
    bsy_r  <= bsy;
    bex_r  <= bex;
    bey_r  <= bey;
  end

  always_ff @(posedge clk) begin
    p_r[0]  <= PW'(dax1_r) * PW'(asy_r);
    p_r[1]  <= PW'(day1_r) * PW'(asx_r);
    p_r[2]  <= PW'(dbx1_r) * PW'(bsy_r);
    p_r[3]  <= PW'(dby1_r) * PW'(bsx_r);
    p_r[4]  <= PW'(dax1_r) * PW'(bsy_r);
    p_r[5]  <= PW'(day1_r) * PW'(bsx_r);
    p_r[6]  <= PW'(dax1_r) * PW'(bey_r);
    p_r[7]  <= PW'(day1_r) * PW'(bex_r);
    p_r[8]  <= PW'(dbx1_r) * PW'(asy_r);
    p_r[9]  <= PW'(dby1_r) * PW'(asx_r);
    p_r[10] <= PW'(dbx1_r) * PW'(aey_r);
    p_r[11] <= PW'(dby1_r) * PW'(aex_r);
    p_r[12] <= PW'(dax1_r) * PW'(dby1_r);
    p_r[13] <= PW'(day1_r) * PW'(dbx1_r);
    dax2_r  <= dax1_r;
    day2_r  <= day1_r;
    dbx2_r  <= dbx1_r;
    dby2_r  <= dby1_r;
  end

  always_comb begin
    ca_nxt  = KW'(p_r[0]) - KW'(p_r[1]);
    cb_nxt  = KW'(p_r[2]) - KW'(p_r[3]);
    tas_nxt = KW'(p_r[4]) - KW'(p_r[5]);
    tae_nxt = KW'(p_r[6]) - KW'(p_r[7]);
    tbs_nxt = KW'(p_r[8]) - KW'(p_r[9]);
    tbe_nxt = KW'(p_r[10]) - KW'(p_r[11]);
    det_nxt = KW'(p_r[12]) - KW'(p_r[13]);
    hit_nxt = ((tas_nxt < ca_nxt) != (tae_nxt < ca_nxt)) &&
              ((tbs_nxt < cb_nxt) != (tbe_nxt < cb_nxt)) && (det_nxt != '0);
  end

  always_ff @(posedge clk) begin
    ca_r   <= ca_nxt;
    cb_r   <= cb_nxt;
    det3_r <= det_nxt;
    hit3_r <= hit_nxt;
    dax3_r <= dax2_r;
    day3_r <= day2_r;
    dbx3_r <= dbx2_r;
    dby3_r <= dby2_r;
  end

  always_ff @(posedge clk) begin
    m1_r   <= MW'(ca_r) * MW'(dbx3_r);
    m2_r   <= MW'(dax3_r) * MW'(cb_r);
    m3_r   <= MW'(ca_r) * MW'(dby3_r);
    m4_r   <= MW'(day3_r) * MW'(cb_r);
    det4_r <= det3_r;
    hit4_r <= hit3_r;
  end

  always_ff @(posedge clk) begin
    numx_r <= NW'(m1_r) - NW'(m2_r);
    numy_r <= NW'(m3_r) - NW'(m4_r);
    det5_r <= det4_r;
    hit5_r <= hit4_r;
  end

  assign vld_out  = vld_r[FRONT_LAT-1];
  assign hit_out  = hit5_r;
  assign numx_out = numx_r;
  assign numy_out = numy_r;
  assign det_out  = det5_r;
endmodule
`default_nettype wire

/* hw/rtl/sip_fifo.sv */
`default_nettype none
module sip_fifo #(
  parameter int W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [W-1:0]      wr_data,
  input  wire logic              pop,
  output logic [W-1:0]           rd_data,
  output sip_pkg::sip_qstat_t    stat
);
  import sip_pkg::*;

  localparam int AW = $clog2(QDEPTH);
  localparam int LW = $clog2(QDEPTH + 1);

  logic [W-1:0]  mem_r [QDEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [LW-1:0] level_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= AW'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= AW'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        level_r <= LW'(level_r + 1'b1);
      end else if (pop && !push) begin
        level_r <= LW'(level_r - 1'b1);
      end
    end
  end

  assign rd_data    = mem_r[rd_ptr_r];
  assign stat.empty = (level_r == '0);
  assign stat.full  = (level_r == LW'(QDEPTH));
endmodule
`default_nettype wire

/* hw/rtl/sip_div.sv */
`default_nettype none
module sip_div #(
  parameter int NW   = 53,
  parameter int KW   = 35,
  parameter int FRAC = 8
) (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic signed [NW-1:0]            num,
  input  wire logic signed [KW-1:0]            den,
  output logic signed [sip_pkg::OUT_BITS-1:0]  quo
);
  import sip_pkg::*;

  localparam int XW = NW + FRAC;
  localparam int HW = XW - OUT_BITS;
  localparam int CW = (HW > KW) ? HW : KW;

  logic [XW-1:0]       x0_r;
  logic [KW-1:0]       d0_r;
  logic                neg0_r;

  logic [KW-1:0]       rem_r [OUT_BITS+1];
  logic [OUT_BITS-1:0] lo_r  [OUT_BITS+1];
  logic [OUT_BITS-1:0] q_r   [OUT_BITS+1];
  logic [KW-1:0]       d_r   [OUT_BITS+1];
  logic                neg_r [OUT_BITS+1];
  logic                ovf_r [OUT_BITS+1];

  logic [NW-1:0]       num_mag;
  logic [KW-1:0]       den_mag;
  logic                sat;
  logic signed [OUT_BITS-1:0] quo_r;

  assign num_mag = num[NW-1] ? NW'(-num) : NW'(num);
  assign den_mag = den[KW-1] ? KW'(-den) : KW'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r   <= XW'(num_mag) << FRAC;
      d0_r   <= den_mag;
      neg0_r <= num[NW-1] ^ den[KW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= CW'(x0_r[XW-1:OUT_BITS]) >= CW'(d0_r);
      rem_r[0] <= KW'(x0_r[XW-1:OUT_BITS]);
      lo_r[0]  <= x0_r[OUT_BITS-1:0];
      q_r[0]   <= '0;
      d_r[0]   <= d0_r;
      neg_r[0] <= neg0_r;
    end
  end

  for (genvar i = 0; i < OUT_BITS; i++) begin : g_step
    logic [KW:0] trial;
    logic        ge;
    assign trial = {rem_r[i], lo_r[i][OUT_BITS-1]};
    assign ge    = trial >= {1'b0, d_r[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge ? KW'(trial - {1'b0, d_r[i]}) : KW'(trial);
        lo_r[i+1]  <= lo_r[i] << 1;
        q_r[i+1]   <= {q_r[i][OUT_BITS-2:0], ge};
        d_r[i+1]   <= d_r[i];
        neg_r[i+1] <= neg_r[i];
        ovf_r[i+1] <= ovf_r[i];
      end
    end
  end

  assign sat = ovf_r[OUT_BITS] || q_r[OUT_BITS][OUT_BITS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r[OUT_BITS]) begin
        quo_r <= sat ? {1'b1, {(OUT_BITS-1){1'b0}}} : -$signed(q_r[OUT_BITS]);
      end else begin
        quo_r <= sat ? {1'b0, {(OUT_BITS-1){1'b1}}} : $signed(q_r[OUT_BITS]);
      end
    end
  end

  assign quo = quo_r;
endmodule
`default_nettype wire

/* hw/rtl/segment_intersection_point.sv */
`default_nettype none
// Tests two 2D segments for a crossing and returns the crossing point with FRAC_BITS
// fraction bits, rounded toward zero, or zero with hit low on a miss. One segment pair
// is taken per cycle unless in_stall is high. Each result passes through a cross-product
// and determinant pipeline, then an eight-entry queue, then a restoring divider pipeline
// of OUT_BITS + 3 stages that retires one quotient bit per stage. When the output is
// stalled the divider holds, and input transfers continue until the queue's credit of
// eight items is used up.
`include "assert_macros.svh"
module segment_intersection_point #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [COORD_BITS-1:0]           in_a_start_x,
  input  wire logic signed [COORD_BITS-1:0]           in_a_start_y,
  input  wire logic signed [COORD_BITS-1:0]           in_a_end_x,
  input  wire logic signed [COORD_BITS-1:0]           in_a_end_y,
  input  wire logic signed [COORD_BITS-1:0]           in_b_start_x,
  input  wire logic signed [COORD_BITS-1:0]           in_b_start_y,
  input  wire logic signed [COORD_BITS-1:0]           in_b_end_x,
  input  wire logic signed [COORD_BITS-1:0]           in_b_end_y,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic                                        out_hit,
  output logic signed [sip_pkg::OUT_BITS-1:0]         out_cross_x,
  output logic signed [sip_pkg::OUT_BITS-1:0]         out_cross_y
);
  import sip_pkg::*;

  localparam int KW   = 2 * COORD_BITS + 3;
  localparam int NW   = 3 * COORD_BITS + 5;
  localparam int QW   = 1 + 2 * NW + KW;
  localparam int CNTW = $clog2(QDEPTH + 1);

  logic                 in_xfer;
  logic [CNTW-1:0]      cnt_r;

  logic                 f_vld, f_hit;
  logic signed [NW-1:0] f_numx, f_numy;
  logic signed [KW-1:0] f_det;

  logic [QW-1:0]        q_rd;
  sip_qstat_t           qstat;
  logic                 pop, en;

  logic [DIV_LAT-1:0]   vld_r, hit_r;
  logic signed [OUT_BITS-1:0] qx, qy;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (cnt_r == CNTW'(QDEPTH));

  sip_front #(.CB(COORD_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_in   (in_xfer),
    .asx      (in_a_start_x),
    .asy      (in_a_start_y),
    .aex      (in_a_end_x),
    .aey      (in_a_end_y),
    .bsx      (in_b_start_x),
    .bsy      (in_b_start_y),
    .bex      (in_b_end_x),
    .bey      (in_b_end_y),
    .vld_out  (f_vld),
    .hit_out  (f_hit),
    .numx_out (f_numx),
    .numy_out (f_numy),
    .det_out  (f_det)
  );

  sip_fifo #(.W(QW)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_vld),
    .wr_data ({f_hit, f_numx, f_numy, f_det}),
    .pop     (pop),
    .rd_data (q_rd),
    .stat    (qstat)
  );

  assign en  = !(out_valid && out_stall);
  assign pop = en && !qstat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_xfer && !pop) begin
      cnt_r <= CNTW'(cnt_r + 1'b1);
    end else if (pop && !in_xfer) begin
      cnt_r <= CNTW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_LAT-2:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= {hit_r[DIV_LAT-2:0], q_rd[QW-1]};
    end
  end

  sip_div #(.NW(NW), .KW(KW), .FRAC(FRAC_BITS)) u_div_x (
    .clk (clk),
    .en  (en),
    .num (q_rd[QW-2 -: NW]),
    .den (q_rd[KW-1:0]),
    .quo (qx)
  );

  sip_div #(.NW(NW), .KW(KW), .FRAC(FRAC_BITS)) u_div_y (
    .clk (clk),
    .en  (en),
    .num (q_rd[KW+NW-1 -: NW]),
    .den (q_rd[KW-1:0]),
    .quo (qy)
  );

  assign out_valid   = vld_r[DIV_LAT-1];
  assign out_hit     = hit_r[DIV_LAT-1];
  assign out_cross_x = out_hit ? qx : '0;
  assign out_cross_y = out_hit ? qy : '0;

  `ASSERT_ALWAYS(a_credit_range, clk, rst_n, cnt_r <= CNTW'(QDEPTH), "Credit count above queue depth.")
  `ASSERT_IMPLY(a_push_room, clk, rst_n, f_vld, !qstat.full, "Front pushed into a full queue.")
  `ASSERT_IMPLY(a_idle_empty, clk, rst_n, cnt_r == '0, qstat.empty, "Queue holds items without credit.")
endmodule
`default_nettype wire

/* dv/tb_segment_intersection_point.sv */
`timescale 1ns / 100ps
module tb_segment_intersection_point;
  import sip_pkg::*;

  localparam int CB = 16;
  localparam int FB = 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = FRONT_LAT + QDEPTH + DIV_LAT + 20;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct packed {
    logic                       hit;
    logic signed [OUT_BITS-1:0] x;
    logic signed [OUT_BITS-1:0] y;
  } crossing_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_a_start_x = '0, in_a_start_y = '0, in_a_end_x = '0, in_a_end_y = '0;
  coord_t in_b_start_x = '0, in_b_start_y = '0, in_b_end_x = '0, in_b_end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic signed [OUT_BITS-1:0] out_cross_x, out_cross_y;

  crossing_t pending_crossings[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int hits_seen = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  segment_intersection_point uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [OUT_BITS-1:0] fix_quotient(
    input logic signed [127:0] num, input logic signed [127:0] den);
    logic signed [127:0] q;
    q = (num <<< FB) / den;
    if (q > 128'sd8388607) return 24'sh7FFFFF;
    if (q < -128'sd8388608) return 24'sh800000;
    return q[OUT_BITS-1:0];
  endfunction

  function automatic crossing_t predict_crossing(input coord_t asx, asy, aex, aey,
                                                 input coord_t bsx, bsy, bex, bey);
    longint dax, day, dbx, dby, ca, cb, det;
    logic sa, sb;
    logic signed [127:0] nx, ny;
    crossing_t r;
    dax = longint'(aex) - longint'(asx);
    day = longint'(aey) - longint'(asy);
    dbx = longint'(bex) - longint'(bsx);
    dby = longint'(bey) - longint'(bsy);
    ca = dax * asy - day * asx;
    cb = dbx * bsy - dby * bsx;
    sa = ((dax * bsy - day * bsx) < ca) != ((dax * bey - day * bex) < ca);
    sb = ((dbx * asy - dby * asx) < cb) != ((dbx * aey - dby * aex) < cb);
    det = dax * dby - day * dbx;
    r = '0;
    if (sa && sb && det != 0) begin
      nx = 128'(ca) * 128'(dbx) - 128'(dax) * 128'(cb);
      ny = 128'(ca) * 128'(dby) - 128'(day) * 128'(cb);
      r.hit = 1'b1;
      r.x = fix_quotient(nx, 128'(det));
      r.y = fix_quotient(ny, 128'(det));
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("Mismatch on result %0d, %s: got %0d, expected %0d", received, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    crossing_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (in_valid && !in_stall) begin
        pending_crossings.push_back(predict_crossing(in_a_start_x, in_a_start_y,
          in_a_end_x, in_a_end_y, in_b_start_x, in_b_start_y, in_b_end_x, in_b_end_y));
      end
      if (out_valid && !out_stall) begin
        if (pending_crossings.size() == 0) begin
          $display("Result transfer with no item outstanding");
          errors++;
        end else begin
          want = pending_crossings.pop_front();
          if (out_hit !== want.hit) report_mismatch("hit", out_hit, want.hit);
          if (out_cross_x !== want.x) report_mismatch("cross_x", out_cross_x, want.x);
          if (out_cross_y !== want.y) report_mismatch("cross_y", out_cross_y, want.y);
          if (want.hit) hits_seen++;
        end
        received++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout waiting for a transfer");
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_pair(input coord_t asx, asy, aex, aey, bsx, bsy, bex, bey);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_a_start_x <= asx;
    in_a_start_y <= asy;
    in_a_end_x <= aex;
    in_a_end_y <= aey;
    in_b_start_x <= bsx;
    in_b_start_y <= bsy;
    in_b_end_x <= bex;
    in_b_end_y <= bey;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic test_directed();
    send_pair(0, 0, 10, 10, 0, 10, 10, 0);
    send_pair(-10, -10, 10, 10, -10, 10, 10, -10);
    send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
    send_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767);
    send_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_pair(0, 0, 10, 0, 0, 5, 10, 5);
    send_pair(0, 0, 10, 10, 1, 1, 20, 20);
    send_pair(5, 5, 5, 5, 0, 0, 10, 10);
    send_pair(0, 0, 10, 0, 5, 0, 5, 10);
    send_pair(0, 0, 10, 0, 5, -10, 5, 0);
    send_pair(0, 0, 10, 10, 10, 10, 20, 0);
    send_pair(0, 0, 10, 0, 11, -5, 11, 5);
    send_pair(0, 0, 3, 7, 0, 5, 4, 1);
    send_pair(-1, -1, 2, 1, 0, 3, 1, -4);
    send_pair(-32768, 32767, 32767, -32767, -32767, -32768, 32766, 32767);
    send_pair(100, -200, -300, 400, -250, -150, 50, 300);
    in_valid <= 1'b0;
  endtask

  function automatic coord_t rand_coord(input bit narrow);
    if (narrow) return coord_t'($signed($urandom_range(64)) - 32);
    return coord_t'($urandom);
  endfunction

  task automatic test_random(input int count, input int idle, input int stall);
    coord_t c[8];
    int mode;
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) begin
      mode = $urandom_range(9);
      foreach (c[i]) c[i] = rand_coord(mode < 3);
      if (mode >= 3 && mode < 8) begin
        // Place the second segment across the first by reflecting a random point near its midpoint about that midpoint.
        c[4] = coord_t'((32'(c[0]) + 32'(c[2])) / 2 + $signed($urandom_range(200)) - 100);
        c[5] = coord_t'((32'(c[1]) + 32'(c[3])) / 2 + $signed($urandom_range(200)) - 100);
        c[6] = coord_t'(2 * ((32'(c[0]) + 32'(c[2])) / 2) - 32'(c[4]));
        c[7] = coord_t'(2 * ((32'(c[1]) + 32'(c[3])) / 2) - 32'(c[5]));
      end else if (mode == 8) begin
        c[4] = c[0];
        c[5] = c[1];
      end
      send_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(340, 0, 0);
    test_random(340, 55, 0);
    test_random(340, 0, 55);
    test_random(360, 16, 16);
    stall_pct = 0;
    while (pending_crossings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d segment pairs, checked %0d results, %0d of them crossings.",
             sent, received, hits_seen);
    $display("Phases covered: no idling, sender gaps, receiver stalls and both together.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* segment_intersection_point.f */
+incdir+hw/rtl
hw/rtl/sip_pkg.sv
hw/rtl/sip_front.sv
hw/rtl/sip_fifo.sv
hw/rtl/sip_div.sv
hw/rtl/segment_intersection_point.sv
dv/tb_segment_intersection_point.sv
